/* rtl/core/vjb_pkg.sv */
`timescale 1ns / 1ps

package vjb_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 16;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int ENTRY_W = HANDLE_BITS + 1;
  localparam int SEQ_W   = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 3;
  localparam int QCFG_W  = 7;
  localparam int SKIP_W  = 6;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int OCNT_W  = 7;
  localparam int CMP_W   = (CNT_W > QCFG_W) ? CNT_W : QCFG_W;

  localparam logic [ACT_W-1:0] ACT_ARRIVE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PULL   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_QUEUE_MIN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_QUEUE_MAX = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_SKIP  = 2'd2;

  localparam logic [QCFG_W-1:0] QUEUE_MIN_RST = 7'd4;
  localparam logic [QCFG_W-1:0] QUEUE_MAX_RST = 7'd16;
  localparam logic [SKIP_W-1:0] MAX_SKIP_RST  = 6'd8;

  localparam logic [OCNT_W-1:0] DROP_SAT = 7'd127;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_LATE     = 3'd1,
    ST_PLAYED   = 3'd2,
    ST_CONCEAL  = 3'd3,
    ST_SILENCE  = 3'd4,
    ST_FLUSHED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_ARRIVE,
    OP_LATE,
    OP_PULL,
    OP_FLUSH,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [SKIP_W-1:0]      skip;
    logic [HANDLE_BITS-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [QCFG_W-1:0] queue_min;
    logic [QCFG_W-1:0] queue_max;
    logic [SKIP_W-1:0] max_skip;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PUSH,
    BK_TRIM,
    BK_PULL
  } bk_state_t;

endpackage

/* rtl/core/vjb_front.sv */
`timescale 1ns / 1ps

module vjb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [vjb_pkg::ACT_W-1:0]      action,
  input  logic [vjb_pkg::SEQ_W-1:0]      seq_number,
  input  logic [vjb_pkg::HANDLE_BITS-1:0] frame_handle,
  input  logic [vjb_pkg::SKIP_W-1:0]     max_skip,
  output logic                           cmd_valid,
  output vjb_pkg::cmd_t                  cmd
);

  logic [vjb_pkg::SEQ_W-1:0] expected_r, expected_nxt;
  logic                      cmd_valid_r;
  vjb_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [vjb_pkg::SEQ_W-1:0] diff;

  always_comb begin
    diff         = seq_number - expected_r;
    expected_nxt = expected_r;
    cmd_nxt      = cmd_r;
    if (accept) begin
      cmd_nxt.handle = frame_handle;
      cmd_nxt.skip   = '0;
      unique case (action)
        vjb_pkg::ACT_ARRIVE: begin
          if (diff[vjb_pkg::SEQ_W-1]) begin
            cmd_nxt.op = vjb_pkg::OP_LATE;
          end else begin
            cmd_nxt.op   = vjb_pkg::OP_ARRIVE;
            // gap capped at max_skip placeholders
            cmd_nxt.skip = (diff < vjb_pkg::SEQ_W'(max_skip)) ?
                           vjb_pkg::SKIP_W'(diff) : max_skip;
            expected_nxt = seq_number + 1'b1;
          end
        end
        vjb_pkg::ACT_PULL:  cmd_nxt.op = vjb_pkg::OP_PULL;
        vjb_pkg::ACT_FLUSH: cmd_nxt.op = vjb_pkg::OP_FLUSH;
        default:            cmd_nxt.op = vjb_pkg::OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      expected_r  <= expected_nxt;
      cmd_valid_r <= accept;
    end
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

/* rtl/core/vjb_cmd_fifo.sv */
`timescale 1ns / 1ps

module vjb_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vjb_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output vjb_pkg::cmd_t pop_data
);

  vjb_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    fill_r, fill_nxt;
  logic          do_pop;

  always_comb begin
    do_pop     = pop && (fill_r != 2'd0);
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (fill_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

endmodule

/* rtl/core/vjb_back.sv */
`timescale 1ns / 1ps

module vjb_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  vjb_pkg::cfg_t                   cfg,
  input  logic                            cmd_ready,
  input  vjb_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  output logic [vjb_pkg::STAT_W-1:0]      out_status,
  output logic [vjb_pkg::HANDLE_BITS-1:0] out_handle,
  output logic [vjb_pkg::OCNT_W-1:0]      out_dropped_count,
  output logic [vjb_pkg::OCNT_W-1:0]      out_queued_count,
  output logic                            out_playing,
  output logic                            out_became_empty
);

  localparam logic [vjb_pkg::IDX_W-1:0] LAST_IDX = vjb_pkg::IDX_W'(vjb_pkg::QUEUE_DEPTH - 1);
  localparam logic [vjb_pkg::CNT_W-1:0] FULL_CNT = vjb_pkg::CNT_W'(vjb_pkg::QUEUE_DEPTH);
  localparam logic [vjb_pkg::SUM_W-1:0] DEPTH_S  = vjb_pkg::SUM_W'(vjb_pkg::QUEUE_DEPTH);

  logic [vjb_pkg::ENTRY_W-1:0] mem [vjb_pkg::QUEUE_DEPTH];
  logic [vjb_pkg::ENTRY_W-1:0] rd_data_r;

  vjb_pkg::bk_state_t state_r, state_nxt;
  logic [vjb_pkg::IDX_W-1:0]       head_r, head_nxt;
  logic [vjb_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            play_r, play_nxt;
  logic [vjb_pkg::SKIP_W-1:0]      ph_r, ph_nxt;
  logic [vjb_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [vjb_pkg::OCNT_W-1:0]      drops_r, drops_nxt;

  logic                            ov_r, ov_nxt;
  logic [vjb_pkg::STAT_W-1:0]      ostat_r, ostat_nxt;
  logic [vjb_pkg::HANDLE_BITS-1:0] ohandle_r, ohandle_nxt;
  logic [vjb_pkg::OCNT_W-1:0]      odrop_r, odrop_nxt;
  logic [vjb_pkg::OCNT_W-1:0]      oqcnt_r, oqcnt_nxt;
  logic                            oplay_r, oplay_nxt;
  logic                            oempty_r, oempty_nxt;

  logic                            mem_we;
  logic [vjb_pkg::IDX_W-1:0]       mem_waddr;
  logic [vjb_pkg::ENTRY_W-1:0]     mem_wdata;
  logic [vjb_pkg::SUM_W-1:0]       tail_sum;
  logic [vjb_pkg::IDX_W-1:0]       head_inc;
  logic [vjb_pkg::OCNT_W-1:0]      drops_inc;
  logic                            min_met;
  logic                            over_max;
  logic                            emit;
  vjb_pkg::status_t                emit_stat;
  logic [vjb_pkg::HANDLE_BITS-1:0] emit_handle;
  logic [vjb_pkg::OCNT_W-1:0]      emit_drop;
  logic                            emit_empty;

  always_comb begin
    tail_sum  = vjb_pkg::SUM_W'(head_r) + vjb_pkg::SUM_W'(count_r);
    head_inc  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    drops_inc = (drops_r == vjb_pkg::DROP_SAT) ? drops_r : drops_r + 1'b1;
    min_met   = vjb_pkg::CMP_W'(count_r) >= vjb_pkg::CMP_W'(cfg.queue_min);
    // count never exceeds the depth, so this also covers queue_max above it
    over_max  = vjb_pkg::CMP_W'(count_r) > vjb_pkg::CMP_W'(cfg.queue_max);

    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    play_nxt   = play_r;
    ph_nxt     = ph_r;
    handle_nxt = handle_r;
    drops_nxt  = drops_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = '0;

    emit        = 1'b0;
    emit_stat   = vjb_pkg::ST_SILENCE;
    emit_handle = '0;
    emit_drop   = '0;
    emit_empty  = 1'b0;

    unique case (state_r)
      vjb_pkg::BK_IDLE: begin
        if (cmd_ready) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            vjb_pkg::OP_ARRIVE: begin
              if (min_met) play_nxt = 1'b1;
              ph_nxt     = cmd.skip;
              handle_nxt = cmd.handle;
              drops_nxt  = '0;
              state_nxt  = vjb_pkg::BK_PUSH;
            end
            vjb_pkg::OP_LATE: begin
              if (min_met) play_nxt = 1'b1;
              emit      = 1'b1;
              emit_stat = vjb_pkg::ST_LATE;
            end
            vjb_pkg::OP_PULL: begin
              if (!play_r) begin
                emit = 1'b1;
              end else if (count_r == '0) begin
                emit      = 1'b1;
                emit_stat = vjb_pkg::ST_CONCEAL;
              end else begin
                state_nxt = vjb_pkg::BK_PULL;
              end
            end
            vjb_pkg::OP_FLUSH: begin
              head_nxt  = '0;
              count_nxt = '0;
              play_nxt  = 1'b0;
              emit      = 1'b1;
              emit_stat = vjb_pkg::ST_FLUSHED;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      vjb_pkg::BK_PUSH: begin
        // one entry a beat: placeholders first, then the frame
        mem_we    = 1'b1;
        mem_wdata = (ph_r != '0) ? '0 : {1'b1, handle_r};
        if (count_r == FULL_CNT) begin
          mem_waddr = head_r;
          head_nxt  = head_inc;
          drops_nxt = drops_inc;
        end else begin
          mem_waddr = (tail_sum >= DEPTH_S) ? vjb_pkg::IDX_W'(tail_sum - DEPTH_S) :
                                              vjb_pkg::IDX_W'(tail_sum);
          count_nxt = count_r + 1'b1;
        end
        if (ph_r != '0) begin
          ph_nxt = ph_r - 1'b1;
        end else begin
          state_nxt = vjb_pkg::BK_TRIM;
        end
      end

      vjb_pkg::BK_TRIM: begin
        if (over_max) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          drops_nxt = drops_inc;
        end else begin
          emit      = 1'b1;
          emit_stat = vjb_pkg::ST_QUEUED;
          emit_drop = drops_r;
          state_nxt = vjb_pkg::BK_IDLE;
        end
      end

      vjb_pkg::BK_PULL: begin
        // rd_data_r holds the head entry, read on the way in
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
        emit      = 1'b1;
        state_nxt = vjb_pkg::BK_IDLE;
        if (rd_data_r[vjb_pkg::HANDLE_BITS]) begin
          emit_stat   = vjb_pkg::ST_PLAYED;
          emit_handle = rd_data_r[vjb_pkg::HANDLE_BITS-1:0];
          if (count_r == vjb_pkg::CNT_W'(1)) begin
            emit_empty = 1'b1;
            play_nxt   = 1'b0;
          end
        end else begin
          emit_stat = vjb_pkg::ST_CONCEAL;
        end
      end

      default: state_nxt = vjb_pkg::BK_IDLE;
    endcase

    ov_nxt      = emit;
    ostat_nxt   = ostat_r;
    ohandle_nxt = ohandle_r;
    odrop_nxt   = odrop_r;
    oqcnt_nxt   = oqcnt_r;
    oplay_nxt   = oplay_r;
    oempty_nxt  = oempty_r;
    if (emit) begin
      ostat_nxt   = emit_stat;
      ohandle_nxt = emit_handle;
      odrop_nxt   = emit_drop;
      oqcnt_nxt   = vjb_pkg::OCNT_W'(count_nxt);
      oplay_nxt   = play_nxt;
      oempty_nxt  = emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vjb_pkg::BK_IDLE;
      head_r  <= '0;
      count_r <= '0;
      play_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      play_r  <= play_nxt;
      ov_r    <= ov_nxt;
    end
    ph_r      <= ph_nxt;
    handle_r  <= handle_nxt;
    drops_r   <= drops_nxt;
    ostat_r   <= ostat_nxt;
    ohandle_r <= ohandle_nxt;
    odrop_r   <= odrop_nxt;
    oqcnt_r   <= oqcnt_nxt;
    oplay_r   <= oplay_nxt;
    oempty_r  <= oempty_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = ostat_r;
  assign out_handle        = ohandle_r;
  assign out_dropped_count = odrop_r;
  assign out_queued_count  = oqcnt_r;
  assign out_playing       = oplay_r;
  assign out_became_empty  = oempty_r;

endmodule

/* rtl/core/voice_jitter_buffer.sv */
`timescale 1ns / 1ps

// Channel   Ports                                                Beat
// input     start, busy, in_action, in_seq_number,               start && !busy
//           in_frame_handle
// result    out_valid, out_status, out_handle, out_dropped_count, out_valid, one cycle
//           out_queued_count, out_playing, out_became_empty
// config    cfg_we, cfg_index, cfg_data                          cfg_we
//
// One item at a time: busy rises on the accepting edge and falls after the result strobe.
// Each command is registered in the front end, written to the command FIFO, taken by the
// back end and its result registered; a pull that dequeues adds a registered head read.
// Arrival: the back end writes (placeholders, then the frame) or discards one queue entry
// per cycle. The next start is taken in the cycle after the result strobe.
// Synchronous reset empties the queue and restores config defaults; no clearing pass.
// Results cannot be stalled; each is shown for exactly one cycle.

module voice_jitter_buffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [vjb_pkg::ACT_W-1:0]       in_action,
  input  logic [vjb_pkg::SEQ_W-1:0]       in_seq_number,
  input  logic [vjb_pkg::HANDLE_BITS-1:0] in_frame_handle,
  output logic                            out_valid,
  output logic [vjb_pkg::STAT_W-1:0]      out_status,
  output logic [vjb_pkg::HANDLE_BITS-1:0] out_handle,
  output logic [vjb_pkg::OCNT_W-1:0]      out_dropped_count,
  output logic [vjb_pkg::OCNT_W-1:0]      out_queued_count,
  output logic                            out_playing,
  output logic                            out_became_empty,
  input  logic                            cfg_we,
  input  logic [vjb_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [vjb_pkg::CFG_W-1:0]       cfg_data
);

  vjb_pkg::cfg_t cfg_r, cfg_nxt;
  logic          busy_r, busy_nxt;
  logic          accept;
  logic          front_valid;
  vjb_pkg::cmd_t front_cmd;
  logic          fifo_ne;
  vjb_pkg::cmd_t fifo_cmd;
  logic          back_pop;
  logic          res_valid;

  assign accept = start && !busy_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        vjb_pkg::CFG_QUEUE_MIN: cfg_nxt.queue_min = cfg_data;
        vjb_pkg::CFG_QUEUE_MAX: cfg_nxt.queue_max = cfg_data;
        vjb_pkg::CFG_MAX_SKIP:  cfg_nxt.max_skip  = cfg_data[vjb_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (res_valid) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.queue_min <= vjb_pkg::QUEUE_MIN_RST;
      cfg_r.queue_max <= vjb_pkg::QUEUE_MAX_RST;
      cfg_r.max_skip  <= vjb_pkg::MAX_SKIP_RST;
      busy_r          <= 1'b0;
    end else begin
      cfg_r  <= cfg_nxt;
      busy_r <= busy_nxt;
    end
  end

  vjb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (in_action),
    .seq_number   (in_seq_number),
    .frame_handle (in_frame_handle),
    .max_skip     (cfg_r.max_skip),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd)
  );

  vjb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_data (front_cmd),
    .pop       (back_pop),
    .not_empty (fifo_ne),
    .pop_data  (fifo_cmd)
  );

  vjb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd_ready         (fifo_ne),
    .cmd               (fifo_cmd),
    .cmd_pop           (back_pop),
    .out_valid         (res_valid),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_dropped_count (out_dropped_count),
    .out_queued_count  (out_queued_count),
    .out_playing       (out_playing),
    .out_became_empty  (out_became_empty)
  );

  assign busy      = busy_r;
  assign out_valid = res_valid;

endmodule

/* tb/tb_voice_jitter_buffer.sv */
`timescale 1ns / 1ps

import vjb_pkg::*;

typedef struct packed {
  logic [ACT_W-1:0]       action;
  logic [SEQ_W-1:0]       seq;
  logic [HANDLE_BITS-1:0] handle;
} jb_item_t;

typedef struct packed {
  status_t                status;
  logic [HANDLE_BITS-1:0] handle;
  logic [OCNT_W-1:0]      dropped;
  logic [OCNT_W-1:0]      queued;
  logic                   playing;
  logic                   emptied;
} jb_res_t;

// Shadow of the jitter queue; predicts one result per accepted beat.
class jb_tracker;
  logic [ENTRY_W-1:0] slots [QUEUE_DEPTH];
  int unsigned        head;
  int unsigned        fill;
  int unsigned        trimmed;
  logic [SEQ_W-1:0]   next_seq;
  logic               play_on;
  logic [QCFG_W-1:0]  q_min;
  logic [QCFG_W-1:0]  q_max;
  logic [SKIP_W-1:0]  skip_cap;
  jb_res_t            awaited [$];
  int                 fails;

  function new();
    head     = 0;
    fill     = 0;
    next_seq = '0;
    play_on  = 1'b0;
    q_min    = QUEUE_MIN_RST;
    q_max    = QUEUE_MAX_RST;
    skip_cap = MAX_SKIP_RST;
    fails    = 0;
  endfunction

  function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_QUEUE_MIN: q_min = data;
      CFG_QUEUE_MAX: q_max = data;
      CFG_MAX_SKIP:  skip_cap = data[SKIP_W-1:0];
      default: ;
    endcase
  endfunction

  function void pop_head();
    if (fill == 0) return;
    head = (head + 1) % QUEUE_DEPTH;
    fill--;
    trimmed++;
  endfunction

  function void push_slot(logic [ENTRY_W-1:0] v);
    if (fill >= QUEUE_DEPTH) pop_head();
    slots[(head + fill) % QUEUE_DEPTH] = v;
    fill++;
  endfunction

  function void take_item(jb_item_t it);
    jb_res_t            r;
    logic [SEQ_W-1:0]   gap;
    int unsigned        fill_prior;
    int unsigned        n_skip;
    int unsigned        lim;
    int unsigned        i;
    logic [ENTRY_W-1:0] e;
    r.status  = ST_SILENCE;
    r.handle  = '0;
    r.dropped = '0;
    r.emptied = 1'b0;
    case (it.action)
      ACT_ARRIVE: begin
        fill_prior = fill;
        gap = it.seq - next_seq;
        if (gap[SEQ_W-1]) begin
          r.status = ST_LATE;
        end else begin
          n_skip  = (gap < skip_cap) ? gap : skip_cap;
          lim     = (q_max > QUEUE_DEPTH) ? QUEUE_DEPTH : q_max;
          trimmed = 0;
          for (i = 0; i < n_skip; i++) push_slot('0);
          push_slot({1'b1, it.handle});
          while (fill > lim) pop_head();
          r.dropped = (trimmed > DROP_SAT) ? DROP_SAT : trimmed[OCNT_W-1:0];
          next_seq  = it.seq + 1;
          r.status  = ST_QUEUED;
        end
        // switch-on looks at the count ahead of the arrival, late or not
        if (fill_prior >= q_min) play_on = 1'b1;
      end
      ACT_PULL: begin
        if (!play_on) begin
          r.status = ST_SILENCE;
        end else if (fill == 0) begin
          r.status = ST_CONCEAL;
        end else begin
          e    = slots[head];
          head = (head + 1) % QUEUE_DEPTH;
          fill--;
          if (e[HANDLE_BITS]) begin
            r.status = ST_PLAYED;
            r.handle = e[HANDLE_BITS-1:0];
            if (fill == 0) begin
              r.emptied = 1'b1;
              play_on   = 1'b0;
            end
          end else begin
            r.status = ST_CONCEAL;
          end
        end
      end
      ACT_FLUSH: begin
        head     = 0;
        fill     = 0;
        play_on  = 1'b0;
        r.status = ST_FLUSHED;
      end
      default: ;
    endcase
    r.queued  = fill[OCNT_W-1:0];
    r.playing = play_on;
    awaited.push_back(r);
  endfunction

  function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  function void match_result(jb_res_t got);
    jb_res_t want;
    if (awaited.size() == 0) begin
      $error("status: expected no result, got %0d", got.status);
      fails++;
      return;
    end
    want = awaited.pop_front();
    cmp_field("status", 32'(want.status), 32'(got.status));
    cmp_field("out_handle", 32'(want.handle), 32'(got.handle));
    cmp_field("dropped_count", 32'(want.dropped), 32'(got.dropped));
    cmp_field("queued_count", 32'(want.queued), 32'(got.queued));
    cmp_field("playing", 32'(want.playing), 32'(got.playing));
    cmp_field("became_empty", 32'(want.emptied), 32'(got.emptied));
  endfunction
endclass

module tb_voice_jitter_buffer;

  localparam int HALF_PERIOD = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int RAND_ITEMS  = 640;
  localparam int PHASES      = 9;

  localparam logic [CIDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACT_W-1:0]       in_action = ACT_PULL;
  logic [SEQ_W-1:0]       in_seq_number = '0;
  logic [HANDLE_BITS-1:0] in_frame_handle = '0;
  logic                   out_valid;
  logic [STAT_W-1:0]      out_status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [OCNT_W-1:0]      out_dropped_count;
  logic [OCNT_W-1:0]      out_queued_count;
  logic                   out_playing;
  logic                   out_became_empty;
  logic                   cfg_we = 1'b0;
  logic [CIDX_W-1:0]      cfg_index = CFG_QUEUE_MIN;
  logic [CFG_W-1:0]       cfg_data = '0;

  jb_tracker trk = new();
  logic      busy_s = 1'b0;
  int        quiet = 0;

  always #(HALF_PERIOD) clk = ~clk;

  voice_jitter_buffer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_seq_number     (in_seq_number),
    .in_frame_handle   (in_frame_handle),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_dropped_count (out_dropped_count),
    .out_queued_count  (out_queued_count),
    .out_playing       (out_playing),
    .out_became_empty  (out_became_empty),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // mid-cycle sampling: everything seen here is what the next rising edge acts on
  always @(negedge clk) begin
    jb_res_t got;
    busy_s = busy;
    if (rst_n && out_valid) begin
      got.status  = status_t'(out_status);
      got.handle  = out_handle;
      got.dropped = out_dropped_count;
      got.queued  = out_queued_count;
      got.playing = out_playing;
      got.emptied = out_became_empty;
      trk.match_result(got);
    end
    if (out_valid || (start && !busy)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [SEQ_W-1:0] seq,
                           logic [HANDLE_BITS-1:0] hnd);
    jb_item_t it;
    it.action = act;
    it.seq    = seq;
    it.handle = hnd;
    in_action       <= act;
    in_seq_number   <= seq;
    in_frame_handle <= hnd;
    start           <= 1'b1;
    do @(posedge clk); while (busy_s);
    trk.take_item(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (trk.awaited.size() != 0 || busy_s) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    trk.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] qmin, logic [CFG_W-1:0] qmax,
                              logic [CFG_W-1:0] skip, bit spare);
    write_reg(CFG_QUEUE_MIN, qmin);
    write_reg(CFG_QUEUE_MAX, qmax);
    write_reg(CFG_MAX_SKIP, skip);
    if (spare) write_reg(CFG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic jb_item_t pick_item();
    jb_item_t         it;
    int               r;
    logic [SEQ_W-1:0] off;
    it.seq    = $urandom;
    it.handle = HANDLE_BITS'($urandom);
    r = $urandom_range(0, 99);
    if (r < 48) it.action = ACT_ARRIVE;
    else if (r < 94) it.action = ACT_PULL;
    else if (r < 97) it.action = ACT_FLUSH;
    else it.action = ACT_UNUSED;
    if (it.action == ACT_ARRIVE) begin
      r = $urandom_range(0, 99);
      if (r < 65) off = '0;
      else if (r < 82) off = $urandom_range(1, 6);
      else if (r < 88) off = $urandom_range(7, 80);
      else if (r < 94) off = -$urandom_range(1, 40);
      else off = $urandom;
      it.seq = trk.next_seq + off;
    end
    return it;
  endfunction

  initial begin
    jb_item_t it;
    int       n;
    int       ph;
    bit       no_idle;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: silence, undefined code, flush of an empty queue, capped gap
    send_item(ACT_PULL, $urandom, HANDLE_BITS'($urandom));
    send_item(ACT_UNUSED, $urandom, HANDLE_BITS'($urandom));
    send_item(ACT_FLUSH, $urandom, HANDLE_BITS'($urandom));
    send_item(ACT_ARRIVE, trk.next_seq + 32'd9, 16'h1234);
    send_item(ACT_FLUSH, $urandom, HANDLE_BITS'($urandom));
    settle();

    program_regs(7'd2, 7'd4, 7'd3, 1'b0);
    send_item(ACT_ARRIVE, trk.next_seq, 16'h0000);
    send_item(ACT_ARRIVE, trk.next_seq, 16'hFFFF);
    send_item(ACT_ARRIVE, trk.next_seq + 32'd2, 16'h5A5A);
    send_item(ACT_ARRIVE, trk.next_seq - 32'd2, 16'h0001);
    send_item(ACT_ARRIVE, trk.next_seq + 32'h7FFF_FFFF, 16'hA5A5);
    send_item(ACT_ARRIVE, trk.next_seq + 32'h8000_0000, 16'hC3C3);
    // placeholders, then the last real frame empties the queue, then silence
    repeat (5) send_item(ACT_PULL, $urandom, HANDLE_BITS'($urandom));
    send_item(ACT_ARRIVE, trk.next_seq, 16'h8001);
    send_item(ACT_FLUSH, $urandom, HANDLE_BITS'($urandom));
    settle();

    // zero queue limit drops everything; playing with nothing queued conceals
    program_regs(7'd0, 7'd0, 7'h3F, 1'b0);
    send_item(ACT_ARRIVE, trk.next_seq + 32'd5, 16'h7777);
    send_item(ACT_PULL, $urandom, HANDLE_BITS'($urandom));
    settle();

    // oversize limits and a skip write with the top bit set; store overflow
    program_regs(7'h7F, 7'h7F, 7'h7F, 1'b1);
    send_item(ACT_ARRIVE, trk.next_seq + 32'd63, 16'h0F0F);
    send_item(ACT_ARRIVE, trk.next_seq + 32'd10, 16'hF0F0);
    send_item(ACT_PULL, $urandom, HANDLE_BITS'($urandom));
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(7'd4, 7'd16, 7'd8, 1'b0);
        1: program_regs(7'd0, 7'd1, 7'd0, 1'b0);
        2: program_regs(7'd127, 7'd127, 7'd63, 1'b0);
        3: program_regs(7'd64, 7'd64, 7'd63, 1'b0);
        4: program_regs(7'd1, 7'd0, 7'd12, 1'b0);
        5: program_regs(7'd2, 7'd8, 7'd3, 1'b1);
        6: program_regs(7'd3, 7'd127, 7'd1, 1'b0);
        7: program_regs(7'd0, 7'd64, 7'd63, 1'b0);
        default: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b0);
      endcase
      no_idle = (ph % 3 == 1);
      for (n = 0; n < RAND_ITEMS / PHASES; n++) begin
        it = pick_item();
        send_item(it.action, it.seq, it.handle);
        n = n + 0;
        begin
          int g;
          g = pick_gap(no_idle);
          if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
          end
        end
      end
      settle();
    end

    start <= 1'b0;
    while (trk.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trk.fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/vjb_pkg.sv
rtl/core/vjb_front.sv
rtl/core/vjb_cmd_fifo.sv
rtl/core/vjb_back.sv
rtl/core/voice_jitter_buffer.sv
tb/tb_voice_jitter_buffer.sv
